[hw/rtl/snt_pkg.sv]
// Shared types and constants for the sorted name table.
// Used by every module under hw/rtl except snt_ram; depends on nothing else.
package snt_pkg;

  localparam int unsigned DepthDef    = 64;
  localparam int unsigned HandleWDef  = 16;
  localparam int unsigned KeyHiW      = 64;
  localparam int unsigned KeyLoW      = 24;
  localparam int unsigned KeyW        = KeyHiW + KeyLoW;
  localparam int unsigned HandlePortW = 16;
  localparam int unsigned PosW        = 6;

  typedef enum logic {
    OP_LOOKUP = 1'b0,
    OP_INSERT = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    STS_OK        = 2'd0,
    STS_NOT_FOUND = 2'd1,
    STS_FULL      = 2'd2,
    STS_REPLACED  = 2'd3
  } status_e;

  typedef struct packed {
    op_e                    operation;
    logic [KeyHiW-1:0]      key_high;
    logic [KeyLoW-1:0]      key_low;
    logic [HandlePortW-1:0] handle_in;
  } in_item_t;

  typedef struct packed {
    status_e                status;
    logic [HandlePortW-1:0] handle_out;
    logic [PosW-1:0]        position;
  } out_item_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic    load;
    logic    srch_rd;
    logic    srch_cmp;
    logic    shift_start;
    logic    shift_step;
    logic    write_entry;
    logic    res_load;
    status_e res_status;
  } ctrl_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic search_done;
    logic hit;
    logic is_insert;
    logic full;
    logic no_shift;
    logic shift_last;
  } dp_sts_t;

endpackage

[hw/rtl/snt_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
// Standalone; no package needed.
module snt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

[hw/rtl/snt_datapath.sv]
// Datapath of the sorted name table: search bounds, shift pointer, entry RAM,
// result register. Depends on snt_pkg and snt_ram.
module snt_datapath import snt_pkg::*; #(
  parameter int unsigned DEPTH        = DepthDef,
  parameter int unsigned HANDLE_WIDTH = HandleWDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  in_item_t  in_data_i,
  input  ctrl_cmd_t cmd_i,
  output dp_sts_t   sts_o,
  output out_item_t out_data_o
);

  localparam int unsigned IdxW = $clog2(DEPTH);
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam int unsigned EntW = KeyW + HANDLE_WIDTH;

  op_e                     op_q;
  logic [KeyW-1:0]         key_q;
  logic [HANDLE_WIDTH-1:0] h_q;
  logic [HANDLE_WIDTH-1:0] hit_h_q;
  logic [CntW-1:0]         lo_q, hi_q, cnt_q;
  logic                    hit_q;
  logic [IdxW-1:0]         ptr_q;
  out_item_t               out_q;

  logic [CntW-1:0]         mid;
  logic [CntW-1:0]         cnt_m1;
  logic [EntW-1:0]         rd_data;
  logic [KeyW-1:0]         rd_key;
  logic [HANDLE_WIDTH-1:0] rd_h;
  logic                    rd_en, wr_en;
  logic [IdxW-1:0]         rd_addr, wr_addr;
  logic [EntW-1:0]         wr_data;
  logic [HandlePortW-1:0]  res_handle;

  assign mid    = lo_q + ((hi_q - lo_q) >> 1);
  assign cnt_m1 = cnt_q - CntW'(1);
  assign rd_key = rd_data[EntW-1 -: KeyW];
  assign rd_h   = rd_data[HANDLE_WIDTH-1:0];

  // Select the RAM read address
  always_comb begin
    rd_en   = cmd_i.srch_rd | cmd_i.shift_start | cmd_i.shift_step;
    rd_addr = mid[IdxW-1:0];
    if (cmd_i.shift_start) begin
      rd_addr = cnt_m1[IdxW-1:0];
    end else if (cmd_i.shift_step) begin
      rd_addr = ptr_q - IdxW'(1);
    end
  end

  // Select the RAM write: move an entry up during the shift, else place the new one
  always_comb begin
    wr_en   = cmd_i.shift_step | cmd_i.write_entry;
    wr_addr = lo_q[IdxW-1:0];
    wr_data = {key_q, h_q};
    if (cmd_i.shift_step) begin
      wr_addr = ptr_q + IdxW'(1);
      wr_data = rd_data;
    end
  end

  snt_ram #(
    .WIDTH (EntW),
    .DEPTH (DEPTH)
  ) u_entry_ram (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  // Capture the transaction payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q  <= in_data_i.operation;
      key_q <= {in_data_i.key_high, in_data_i.key_low};
      h_q   <= HANDLE_WIDTH'(in_data_i.handle_in);
    end
  end

  // Narrow the search bounds; note an exact match
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lo_q  <= '0;
      hi_q  <= '0;
      hit_q <= 1'b0;
    end else if (cmd_i.load) begin
      lo_q  <= '0;
      hi_q  <= cnt_q;
      hit_q <= 1'b0;
    end else if (cmd_i.srch_cmp) begin
      if (rd_key < key_q) begin
        lo_q <= mid + CntW'(1);
      end else begin
        hi_q <= mid;
      end
      if (rd_key == key_q) begin
        hit_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.srch_cmp && (rd_key == key_q)) begin
      hit_h_q <= rd_h;
    end
  end

  // Walk the shift pointer down from the top entry
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q <= '0;
    end else if (cmd_i.shift_start) begin
      ptr_q <= cnt_m1[IdxW-1:0];
    end else if (cmd_i.shift_step) begin
      ptr_q <= ptr_q - IdxW'(1);
    end
  end

  // Advance the fill count on a new entry
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.write_entry && !hit_q) begin
      cnt_q <= cnt_q + CntW'(1);
    end
  end

  // Form and hold the result
  always_comb begin
    res_handle = '0;
    if (cmd_i.res_status == STS_OK || cmd_i.res_status == STS_REPLACED) begin
      res_handle = (op_q == OP_INSERT) ? HandlePortW'(h_q) : HandlePortW'(hit_h_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.res_load) begin
      out_q.status     <= cmd_i.res_status;
      out_q.handle_out <= res_handle;
      out_q.position   <= PosW'(lo_q);
    end
  end

  assign out_data_o = out_q;

  assign sts_o.search_done = (lo_q == hi_q);
  assign sts_o.hit         = hit_q;
  assign sts_o.is_insert   = (op_q == OP_INSERT);
  assign sts_o.full        = (cnt_q == CntW'(DEPTH));
  assign sts_o.no_shift    = (lo_q == cnt_q);
  assign sts_o.shift_last  = (ptr_q == lo_q[IdxW-1:0]);

endmodule

[hw/rtl/snt_ctrl.sv]
// Controller of the sorted name table: sequences search, shift, write, result.
// Depends on snt_pkg.
module snt_ctrl import snt_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  input  dp_sts_t   sts_i,
  output ctrl_cmd_t cmd_o
);

  typedef enum logic [6:0] {
    S_IDLE        = 7'b0000001,
    S_SEARCH      = 7'b0000010,
    S_COMPARE     = 7'b0000100,
    S_SHIFT_START = 7'b0001000,
    S_SHIFT       = 7'b0010000,
    S_WRITE       = 7'b0100000,
    S_RESULT      = 7'b1000000
  } state_e;

  state_e  state_q, state_d;
  status_e res_q, res_d;
  logic    out_valid_q, out_valid_d;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  // Next state and command decode
  always_comb begin
    state_d     = state_q;
    res_d       = res_q;
    out_valid_d = out_valid_q & ~out_ready_i;
    cmd_o       = '0;
    cmd_o.res_status = res_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_SEARCH;
        end
      end
      S_SEARCH: begin
        if (!sts_i.search_done) begin
          cmd_o.srch_rd = 1'b1;
          state_d       = S_COMPARE;
        end else if (!sts_i.is_insert) begin
          res_d   = sts_i.hit ? STS_OK : STS_NOT_FOUND;
          state_d = S_RESULT;
        end else if (sts_i.hit) begin
          state_d = S_WRITE;
        end else if (sts_i.full) begin
          res_d   = STS_FULL;
          state_d = S_RESULT;
        end else if (sts_i.no_shift) begin
          state_d = S_WRITE;
        end else begin
          state_d = S_SHIFT_START;
        end
      end
      S_COMPARE: begin
        cmd_o.srch_cmp = 1'b1;
        state_d        = S_SEARCH;
      end
      S_SHIFT_START: begin
        cmd_o.shift_start = 1'b1;
        state_d           = S_SHIFT;
      end
      S_SHIFT: begin
        cmd_o.shift_step = 1'b1;
        if (sts_i.shift_last) begin
          state_d = S_WRITE;
        end
      end
      S_WRITE: begin
        cmd_o.write_entry = 1'b1;
        res_d             = sts_i.hit ? STS_REPLACED : STS_OK;
        state_d           = S_RESULT;
      end
      S_RESULT: begin
        // Hold until the output register is free
        if (!out_valid_q || out_ready_i) begin
          cmd_o.res_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      res_q       <= STS_OK;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      res_q       <= res_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

[hw/rtl/sorted_name_table.sv]
// Sorted name table top level: controller plus datapath with one entry RAM.
// A lookup repeats a binary-search step (RAM read, then compare) until the bounds
// meet; an insert that moves entries then shifts them up one at a time through the
// single RAM port before the write; a replace or an append goes straight to the
// write, a refused insert to the result. One transaction is in work at a time.
// Reset clears the fill count and control; the RAM is not cleared and needs no pass.
module sorted_name_table import snt_pkg::*; #(
  parameter int unsigned DEPTH        = DepthDef,
  parameter int unsigned HANDLE_WIDTH = HandleWDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_data_o
);

  ctrl_cmd_t cmd;
  dp_sts_t   sts;

  snt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  snt_datapath #(
    .DEPTH        (DEPTH),
    .HANDLE_WIDTH (HANDLE_WIDTH)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_data_i  (in_data_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_data_o (out_data_o)
  );

endmodule
